// ===== rtl/hts_pkg.sv =====
// hts_pkg: shared types and constants for the html tag stripper
// no dependencies; compile first
`default_nettype none

package hts_pkg;

  localparam int unsigned BYTE_W = 8;

  // tag patterns, oldest character in the most significant byte
  localparam logic [55:0] PAT_OPEN_SCRIPT  = "<script";
  localparam logic [47:0] PAT_OPEN_STYLE   = "<style";
  localparam logic [63:0] PAT_CLOSE_SCRIPT = "</script";
  localparam logic [55:0] PAT_CLOSE_STYLE  = "</style";

  localparam logic [BYTE_W-1:0] CHR_LT    = 8'h3C;
  localparam logic [BYTE_W-1:0] CHR_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] VIS_LO    = 8'h21;
  localparam logic [BYTE_W-1:0] VIS_HI    = 8'h7E;

  // one queued result
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_text;
  } result_t;

  // results produced by one accepted request
  typedef struct packed {
    logic    data_valid;
    result_t data;
    logic    term_valid;
    result_t term;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/hts_if.sv =====
// hts_in_if / hts_out_if: valid-ready channels of the tag stripper
// depends on nothing but the payload widths below
`default_nettype none

interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;
  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_text;
  modport source (output valid, output out_byte, output end_of_text, input ready);
  modport sink   (input valid, input out_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/hts_filter.sv =====
// hts_filter: tag/script state and byte filtering for one accepted request a cycle
// depends on hts_pkg
`default_nettype none

module hts_filter (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   last,
  output hts_pkg::push_t              push
);
  import hts_pkg::*;

  logic        pass_on_r, pass_on_nxt;
  logic        in_content_r, in_content_nxt;
  logic        space_allowed_r, space_allowed_nxt;
  logic [55:0] recent_r, recent_nxt;

  logic [63:0]       window;
  logic [BYTE_W-1:0] v;
  logic [BYTE_W-1:0] emitted;
  logic              pass_upd;
  logic              visible;
  logic              hit_open;
  logic              hit_close;

  assign window = {recent_r, in_byte};

  always_comb begin
    v        = in_byte;
    pass_upd = pass_on_r;
    if (in_byte == CHR_LT) begin
      pass_upd = 1'b0;
    end else if (in_byte == CHR_GT) begin
      pass_upd = in_content_r;
      v        = CHR_SPACE;
    end
  end

  assign hit_open  = (window[55:0] == PAT_OPEN_SCRIPT) || (window[47:0] == PAT_OPEN_STYLE);
  assign hit_close = (window == PAT_CLOSE_SCRIPT) || (window[55:0] == PAT_CLOSE_STYLE);

  assign emitted = pass_upd ? v : CHR_SPACE;
  assign visible = (emitted >= VIS_LO) && (emitted <= VIS_HI);

  always_comb begin
    pass_on_nxt       = pass_on_r;
    in_content_nxt    = in_content_r;
    space_allowed_nxt = space_allowed_r;
    recent_nxt        = recent_r;
    push.data_valid       = 1'b0;
    push.data.out_byte    = emitted;
    push.data.end_of_text = 1'b0;
    push.term_valid       = 1'b0;
    push.term.out_byte    = '0;
    push.term.end_of_text = 1'b1;
    if (accept) begin
      pass_on_nxt = pass_upd;
      if (hit_open) begin
        in_content_nxt = 1'b0;
      end else if (hit_close) begin
        in_content_nxt = 1'b1;
      end
      recent_nxt = window[55:0];
      if (visible) begin
        space_allowed_nxt = 1'b1;
        push.data_valid   = 1'b1;
      end else if (space_allowed_r) begin
        space_allowed_nxt = 1'b0;
        push.data_valid   = 1'b1;
      end
      if (last) begin
        push.term_valid   = 1'b1;
        pass_on_nxt       = 1'b1;
        in_content_nxt    = 1'b1;
        space_allowed_nxt = 1'b1;
        recent_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_on_r       <= 1'b1;
      in_content_r    <= 1'b1;
      space_allowed_r <= 1'b1;
      recent_r        <= '0;
    end else begin
      pass_on_r       <= pass_on_nxt;
      in_content_r    <= in_content_nxt;
      space_allowed_r <= space_allowed_nxt;
      recent_r        <= recent_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hts_queue.sv =====
// hts_queue: small result queue taking up to two writes and one read a cycle
// depends on hts_pkg
`default_nettype none

module hts_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire hts_pkg::push_t             push,
  input  wire logic                       pop,
  output hts_pkg::result_t                head,
  output logic [$clog2(DEPTH):0]          count
);
  import hts_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr1;
  logic               wr0, wr1;
  result_t            e0;
  logic [1:0]         n_push;

  // first slot takes the data result if there is one, else the terminator
  assign wr0     = push.data_valid || push.term_valid;
  assign wr1     = push.data_valid && push.term_valid;
  assign e0      = push.data_valid ? push.data : push.term;
  assign wr_ptr1 = wr_ptr_r + PTR_W'(1);
  assign n_push  = {1'b0, push.data_valid} + {1'b0, push.term_valid};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (wr0 && (wr_ptr_r == PTR_W'(i))) begin
        mem_r[i] <= e0;
      end else if (wr1 && (wr_ptr1 == PTR_W'(i))) begin
        mem_r[i] <= push.term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ===== rtl/html_tag_stripper.sv =====
// html_tag_stripper: drops markup, blanks script/style bodies, collapses blanks
// a request's first result is queued on acceptance and reaches the output once
// earlier results are taken; a second one follows once the first has been taken
// throughput: one request per cycle while in_ch.ready is high; each request gives at most two results,
// so the rate is bounded by the single-result output port and the result queue
// reset: synchronous active-low rst_n clears tag state, byte history and queue
// depends on hts_pkg, hts_if, hts_filter, hts_queue
`default_nettype none

module html_tag_stripper #(
  parameter int unsigned RESULT_DEPTH = 4  // power of two, at least 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hts_in_if.sink    in_ch,
  hts_out_if.source out_ch
);
  import hts_pkg::*;

  localparam int unsigned CNT_W = $clog2(RESULT_DEPTH) + 1;

  logic             in_accept;
  logic             out_pop;
  push_t            push;
  result_t          head;
  logic [CNT_W-1:0] q_count;

  // room for the worst case of a data result plus a terminator
  assign in_ch.ready = (q_count <= CNT_W'(RESULT_DEPTH - 2));
  assign in_accept   = in_ch.valid && in_ch.ready;

  // state update and filtering happen in the cycle of the request
  hts_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_byte (in_ch.in_byte),
    .last    (in_ch.last),
    .push    (push)
  );

  // queue head is the registered result seen on the output channel
  hts_queue #(
    .DEPTH (RESULT_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_pop),
    .head  (head),
    .count (q_count)
  );

  assign out_ch.valid       = (q_count != '0);
  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.end_of_text = head.end_of_text;
  assign out_pop            = out_ch.valid && out_ch.ready;

  // queue never overfills
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(RESULT_DEPTH))
    else $error("result queue overflow");

  // a final byte always leaves something queued for the next cycle
  a_term_queued : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.last) |=> (q_count != '0))
    else $error("terminator not queued");

  // terminator carries a zero byte
  a_term_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_text) |-> (out_ch.out_byte == '0))
    else $error("terminator byte not zero");

  // results are pushed only for an accepted request
  a_push_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    (push.data_valid || push.term_valid) |-> in_accept)
    else $error("result pushed without request");

endmodule

`default_nettype wire
